[hdl/assert_macros.svh]
// Assertion macros for the RTL file that checks itself (edge_list_text_parser.sv).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

[hdl/elp_pkg.sv]
// Shared types and constants of the edge list text parser.
package elp_pkg;

  // characters
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  localparam int RADIX    = 10;
  localparam int OUT_BITS = 32;

  // byte classes carried from front to back
  localparam logic [2:0] CLS_SPACE = 3'd0;
  localparam logic [2:0] CLS_DIGIT = 3'd1;
  localparam logic [2:0] CLS_LF    = 3'd2;
  localparam logic [2:0] CLS_CR    = 3'd3;
  localparam logic [2:0] CLS_OTHER = 3'd4;
  localparam logic [2:0] CLS_EOI   = 3'd5;

  // result kinds
  localparam logic [1:0] KIND_EDGE  = 2'd0;
  localparam logic [1:0] KIND_DONE  = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  typedef struct packed {
    logic [2:0] cls;
    logic [3:0] digit;
  } token_t;

  typedef struct packed {
    logic [1:0]          kind;
    logic [OUT_BITS-1:0] src;
    logic [OUT_BITS-1:0] tgt;
    logic [OUT_BITS-1:0] val;
    logic                last;
  } result_t;

endpackage

[hdl/elp_front.sv]
// Front end: classifies incoming bytes and queues the tokens for the parser.
module elp_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  logic [7:0]     in_input_byte,
  input  logic           in_end_of_input,
  output logic           tok_valid,
  output elp_pkg::token_t tok,
  input  logic           tok_take
);
  import elp_pkg::*;

  token_t     q_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  token_t     cls_tok;
  logic       push, pop;

  // byte classifier
  always_comb begin
    cls_tok.digit = in_input_byte[3:0];
    if (in_end_of_input) begin
      cls_tok.cls = CLS_EOI;
    end else begin
      unique case (in_input_byte) inside
        CHAR_SPACE, CHAR_TAB:   cls_tok.cls = CLS_SPACE;
        [CHAR_ZERO:CHAR_NINE]:  cls_tok.cls = CLS_DIGIT;
        CHAR_LF:                cls_tok.cls = CLS_LF;
        CHAR_CR:                cls_tok.cls = CLS_CR;
        default:                cls_tok.cls = CLS_OTHER;
      endcase
    end
  end

  assign in_stall  = (cnt_r == 2'd2) | ~rst_n;
  assign push      = in_valid & ~in_stall;
  assign tok_valid = (cnt_r != 2'd0);
  assign pop       = tok_valid & tok_take;
  assign tok       = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push;
    rd_ptr_nxt = rd_ptr_r ^ pop;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= cls_tok;
    end
  end

endmodule

[hdl/elp_back.sv]
// Back end: line parser state machine and the result queue.
module elp_back #(
  parameter int NUMBER_BITS = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             tok_valid,
  input  elp_pkg::token_t  tok,
  output logic             tok_take,
  output logic             out_valid,
  input  logic             out_stall,
  output elp_pkg::result_t out_res
);
  import elp_pkg::*;

  localparam int NB = NUMBER_BITS;

  localparam logic [1:0] MODE_IDLE = 2'd0;
  localparam logic [1:0] MODE_NUM  = 2'd1;
  localparam logic [1:0] MODE_CR   = 2'd2;

  logic [1:0]    mode_r, mode_nxt;
  logic [NB-1:0] acc_r, acc_nxt;
  logic [1:0]    fields_r, fields_nxt;
  logic [NB-1:0] src_r, src_nxt;
  logic [NB-1:0] tgt_r, tgt_nxt;
  logic          err_r, err_nxt;

  result_t       rq_r [4];
  logic [1:0]    wr_r, wr_nxt;
  logic [1:0]    rd_r, rd_nxt;
  logic [2:0]    ocnt_r, ocnt_nxt;

  logic [NB+3:0] prod;
  logic          ovf;
  logic          is_num;
  logic [1:0]    f_fin;
  logic [NB-1:0] src_fin, tgt_fin;
  logic          do_err, do_edge;
  result_t       res0, res1, edge_res, err_res, done_res;
  logic [1:0]    n_res;
  logic          pop;

  // next accumulator value; overflow when anything lands above NB bits
  assign prod = {4'd0, acc_r} * (NB+4)'(RADIX) + (NB+4)'(tok.digit);
  assign ovf  = |prod[NB+3:NB];

  assign tok_take  = tok_valid & (ocnt_r <= 3'd2);
  assign out_valid = (ocnt_r != 3'd0);
  assign pop       = out_valid & ~out_stall;
  assign out_res   = rq_r[rd_r];

  always_comb begin
    edge_res = '{kind: KIND_EDGE, src: OUT_BITS'(src_r), tgt: OUT_BITS'(tgt_r),
                 val: OUT_BITS'(acc_r), last: 1'b1};
    err_res  = '{kind: KIND_ERROR, src: '0, tgt: '0, val: '0, last: 1'b1};
    done_res = '{kind: KIND_DONE, src: '0, tgt: '0, val: '0, last: 1'b1};
  end

  always_comb begin
    mode_nxt   = mode_r;
    acc_nxt    = acc_r;
    fields_nxt = fields_r;
    src_nxt    = src_r;
    tgt_nxt    = tgt_r;
    err_nxt    = err_r;
    res0       = '0;
    res1       = '0;
    n_res      = 2'd0;
    do_err     = 1'b0;
    do_edge    = 1'b0;
    is_num     = (mode_r == MODE_NUM);
    f_fin      = fields_r;
    src_fin    = src_r;
    tgt_fin    = tgt_r;

    // a digit run ends on any non-digit: file the number
    if (is_num && tok.cls != CLS_DIGIT) begin
      if (fields_r == 2'd0) src_fin = acc_r;
      if (fields_r == 2'd1) tgt_fin = acc_r;
      f_fin = fields_r + 2'd1;
    end

    if (tok_take) begin
      if (tok.cls == CLS_EOI) begin
        mode_nxt   = MODE_IDLE;
        acc_nxt    = '0;
        fields_nxt = 2'd0;
        src_nxt    = '0;
        tgt_nxt    = '0;
        err_nxt    = 1'b0;
        if (err_r) begin
          n_res = 2'd0;
        end else if (mode_r == MODE_CR || (f_fin != 2'd3 && f_fin != 2'd0)) begin
          res0  = err_res;
          n_res = 2'd1;
        end else if (f_fin == 2'd3) begin
          res0      = edge_res;
          res0.last = 1'b0;
          res1      = done_res;
          n_res     = 2'd2;
        end else begin
          res0  = done_res;
          n_res = 2'd1;
        end
      end else if (!err_r) begin
        if (mode_r == MODE_CR) begin
          if (tok.cls == CLS_LF) do_edge = 1'b1;
          else                   do_err  = 1'b1;
        end else if (is_num && tok.cls == CLS_DIGIT) begin
          if (ovf) do_err  = 1'b1;
          else     acc_nxt = prod[NB-1:0];
        end else begin
          mode_nxt   = MODE_IDLE;
          fields_nxt = f_fin;
          src_nxt    = src_fin;
          tgt_nxt    = tgt_fin;
          case (tok.cls)
            CLS_SPACE: ;
            CLS_DIGIT: begin
              if (f_fin == 2'd3) begin
                do_err = 1'b1;  // fourth number on a line
              end else begin
                acc_nxt  = NB'(tok.digit);
                mode_nxt = MODE_NUM;
              end
            end
            CLS_LF:    do_edge  = 1'b1;
            CLS_CR:    mode_nxt = MODE_CR;
            default:   do_err   = 1'b1;
          endcase
        end

        // line end with fewer than three numbers is an error
        if (do_edge && f_fin != 2'd3) begin
          do_edge = 1'b0;
          do_err  = 1'b1;
        end

        if (do_err || do_edge) begin
          res0       = do_err ? err_res : edge_res;
          n_res      = 2'd1;
          mode_nxt   = MODE_IDLE;
          acc_nxt    = '0;
          fields_nxt = 2'd0;
          src_nxt    = '0;
          tgt_nxt    = '0;
          err_nxt    = do_err;
        end
      end
    end

    wr_nxt   = wr_r + n_res;
    rd_nxt   = rd_r + {1'b0, pop};
    ocnt_nxt = ocnt_r + {1'b0, n_res} - {2'd0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_IDLE;
      acc_r    <= '0;
      fields_r <= 2'd0;
      src_r    <= '0;
      tgt_r    <= '0;
      err_r    <= 1'b0;
      wr_r     <= 2'd0;
      rd_r     <= 2'd0;
      ocnt_r   <= 3'd0;
    end else begin
      mode_r   <= mode_nxt;
      acc_r    <= acc_nxt;
      fields_r <= fields_nxt;
      src_r    <= src_nxt;
      tgt_r    <= tgt_nxt;
      err_r    <= err_nxt;
      wr_r     <= wr_nxt;
      rd_r     <= rd_nxt;
      ocnt_r   <= ocnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (n_res != 2'd0) begin
      rq_r[wr_r] <= res0;
    end
    if (n_res == 2'd2) begin
      rq_r[wr_r + 2'd1] <= res1;
    end
  end

endmodule

[hdl/edge_list_text_parser.sv]
// Top level of the edge list text parser: front end, token queue, parser back end.
`include "assert_macros.svh"

// Parses a byte stream of "source target value" lines (unsigned decimal, separated
// by spaces or tabs, ended by LF or CR LF) and returns one edge result per complete
// line. A request with in_end_of_input high ends the stream: it returns completion
// (preceded by the last edge when the final line has no line end) or a format
// error, and returns the parser to its reset state for the next stream. A format
// error is reported once; later bytes and the end of input then return no result.
// Throughput is one request per cycle sustained, on both channels, while out_stall
// stays low. An accepted request is classified into a two-entry token queue, which
// the parser reads from; its results are written into the result queue, which
// drives the out_ channel. The per-byte accumulator update (multiply by ten, add
// digit, overflow check on NUMBER_BITS+4 bits) is the loop that sets the clock
// rate. The result queue holds four entries and the parser only takes a token
// while two of them are free, since end of input can return two results (edge,
// then completion; only the final result of a request has out_last_of_run set).
// in_stall is high while the token queue is full and during reset; out_valid
// depends only on the result queue. Numbers wider than 32 bits (NUMBER_BITS
// above 32) come out as their low 32 bits.
module edge_list_text_parser #(
  parameter int NUMBER_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_input_byte,
  input  logic        in_end_of_input,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_result_kind,
  output logic [31:0] out_source_vertex,
  output logic [31:0] out_target_vertex,
  output logic [31:0] out_edge_value,
  output logic        out_last_of_run
);
  import elp_pkg::*;

  logic    tok_valid;
  logic    tok_take;
  token_t  tok;
  result_t out_res;

  // byte classification and token queue
  elp_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_input_byte  (in_input_byte),
    .in_end_of_input(in_end_of_input),
    .tok_valid      (tok_valid),
    .tok            (tok),
    .tok_take       (tok_take)
  );

  // line parser and result queue
  elp_back #(
    .NUMBER_BITS(NUMBER_BITS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .tok_valid(tok_valid),
    .tok      (tok),
    .tok_take (tok_take),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_res  (out_res)
  );

  assign out_result_kind   = out_res.kind;
  assign out_source_vertex = out_res.src;
  assign out_target_vertex = out_res.tgt;
  assign out_edge_value    = out_res.val;
  assign out_last_of_run   = out_res.last;

  // only the edge of an edge+completion pair is ever a non-final result
  `ASSERT_IMPL(a_nonlast_is_edge, out_valid && !out_last_of_run,
               out_result_kind == KIND_EDGE)

  // completion and error results carry zero vertex and value fields
  `ASSERT_IMPL(a_non_edge_zero, out_valid && out_result_kind != KIND_EDGE,
               out_source_vertex == 32'd0 && out_target_vertex == 32'd0 &&
               out_edge_value == 32'd0)

  // the completion behind a non-final edge is queued together with it
  `ASSERT_NEXT(a_pair_follows, out_valid && !out_stall && !out_last_of_run,
               out_valid && out_result_kind == KIND_DONE)

endmodule
